// File: design/sound_chip_timer_interrupt_unit_assert.svh
// assertion macros shared by the timer and interrupt unit
`ifndef SOUND_CHIP_TIMER_INTERRUPT_UNIT_ASSERT_SVH
`define SOUND_CHIP_TIMER_INTERRUPT_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// check that is off while reset is asserted
`define SCTIU_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// check that also holds during reset
`define SCTIU_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SCTIU_ASSERT(label, clk, rst_n, prop, msg)
`define SCTIU_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// File: design/sctiu_pkg.sv
`default_nettype none

package sctiu_pkg;

	// timer count
	localparam int NUM_TIMERS = 3;
	localparam int TIMER_W = 16;
	localparam int TIMER_IRQ_BIT = 6;

	// interrupt bit vectors
	localparam int IRQ_W = 11;
	localparam int HOST_KEY_BIT = 5;
	localparam int LEVEL_REGS = 3;
	localparam int SAT_BIT = 7;

	localparam logic [IRQ_W-1:0] CPU_EN_RESET = 11'h040;
	localparam logic [7:0] LEVEL_IDLE = 8'hFF;

	// register offsets
	localparam logic [15:0] ADDR_TIMER0 = 16'h2890;
	localparam logic [15:0] TIMER_STRIDE = 16'h0004;
	localparam logic [15:0] ADDR_CPU_EN = 16'h289C;
	localparam logic [15:0] ADDR_CPU_PEND = 16'h28A0;
	localparam logic [15:0] ADDR_CPU_CLR = 16'h28A4;
	localparam logic [15:0] ADDR_LEVEL0 = 16'h28A8;
	localparam logic [15:0] ADDR_LEVEL1 = 16'h28AC;
	localparam logic [15:0] ADDR_LEVEL2 = 16'h28B0;
	localparam logic [15:0] ADDR_HOST_EN = 16'h28B4;
	localparam logic [15:0] ADDR_HOST_PEND = 16'h28B8;
	localparam logic [15:0] ADDR_HOST_CLR = 16'h28BC;
	localparam logic [15:0] ADDR_RESET = 16'h2C00;
	localparam logic [15:0] ADDR_REQ_LEVEL = 16'h2D00;
	localparam logic [15:0] ADDR_REQ_CLR = 16'h2D04;

	// kind of word on the request channel
	typedef enum logic [1:0] {
		REQ_READ  = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_TICK  = 2'd2,
		REQ_NONE  = 2'd3
	} req_type_t;

	typedef struct packed {
		req_type_t   req_type;
		logic [15:0] address;
		logic [31:0] write_data;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        cpu_irq_raise;
		logic        host_irq_raise;
		logic        host_irq_clear;
		logic        cpu_run;
	} result_t;

	// outcome of the sound cpu priority scan
	typedef struct packed {
		logic       found;
		logic [2:0] level;
	} scan_t;

endpackage

`default_nettype wire

// File: design/sctiu_req_if.sv
`default_nettype none

interface sctiu_req_if import sctiu_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [15:0] address;
	logic [31:0] write_data;

	modport source(output valid, req_type, address, write_data, input ready);
	modport sink(input valid, req_type, address, write_data, output ready);
endinterface

`default_nettype wire

// File: design/sctiu_rsp_if.sv
`default_nettype none

interface sctiu_rsp_if import sctiu_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [31:0] read_data;
	logic        cpu_irq_raise;
	logic        host_irq_raise;
	logic        host_irq_clear;
	logic        cpu_run;

	modport source(output valid, read_data, cpu_irq_raise, host_irq_raise,
		host_irq_clear, cpu_run, input ready);
	modport sink(input valid, read_data, cpu_irq_raise, host_irq_raise,
		host_irq_clear, cpu_run, output ready);
endinterface

`default_nettype wire

// File: design/sctiu_cfg_if.sv
`default_nettype none

interface sctiu_cfg_if import sctiu_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] cable_kind;

	modport source(output valid, cable_kind, input ready);
	modport sink(input valid, cable_kind, output ready);
endinterface

`default_nettype wire

// File: design/sctiu_prio.sv
`default_nettype none

module sctiu_prio import sctiu_pkg::*; (
	input  logic [IRQ_W-1:0] active,
	input  logic [7:0]       level_bits [LEVEL_REGS],
	output scan_t            scan
);

	logic [7:0] mask;

	// highest active source, saturated at the top level bit
	always_comb begin
		mask = '0;
		if (|active[IRQ_W-1:SAT_BIT]) begin
			mask = 8'h80;
		end else begin
			for (int i = 0; i < SAT_BIT; i++) begin
				if (active[i]) begin
					mask = 8'(1 << i);
				end
			end
		end
	end

	// map mask through the level bit registers
	always_comb begin
		scan.found = |active;
		for (int k = 0; k < LEVEL_REGS; k++) begin
			scan.level[k] = |(level_bits[k] & mask);
		end
	end

endmodule

`default_nettype wire

// File: design/sctiu_core.sv
`default_nettype none
`include "sound_chip_timer_interrupt_unit_assert.svh"

module sctiu_core import sctiu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       exec,
	input  req_t       req,
	input  logic [1:0] cable_kind,
	output result_t    res
);

	logic [TIMER_W-1:0] timer_q [NUM_TIMERS];
	logic [TIMER_W-1:0] timer_d [NUM_TIMERS];
	logic [7:0]         level_q [LEVEL_REGS];
	logic [7:0]         level_d [LEVEL_REGS];
	logic [IRQ_W-1:0]   cpu_en_q, cpu_en_d;
	logic [IRQ_W-1:0]   cpu_pend_q, cpu_pend_d;
	logic [IRQ_W-1:0]   host_en_q, host_en_d;
	logic [IRQ_W-1:0]   host_pend_q, host_pend_d;
	logic [7:0]         req_level_q, req_level_d;
	logic [7:0]         reset_q, reset_d;

	logic [NUM_TIMERS-1:0] wrap;
	logic [IRQ_W-1:0]      tick_set;
	logic [IRQ_W-1:0]      cpu_pend_tick;
	logic [IRQ_W-1:0]      host_pend_tick;
	logic [IRQ_W-1:0]      host_pend_clr;
	logic [31:0]           rd_data;
	scan_t                 scan;

	// timer wrap detection and the pending bits it sets
	always_comb begin
		tick_set = '0;
		for (int i = 0; i < NUM_TIMERS; i++) begin
			wrap[i] = (timer_q[i][7:0] == 8'hFF);
			tick_set[TIMER_IRQ_BIT + i] = wrap[i];
		end
	end

	assign cpu_pend_tick  = cpu_pend_q | tick_set;
	assign host_pend_tick = host_pend_q | tick_set;
	assign host_pend_clr  = host_pend_q & ~req.write_data[IRQ_W-1:0];

	// priority scan on the pending bits as they stand after the tick
	sctiu_prio u_prio (
		.active    (cpu_pend_tick & cpu_en_q),
		.level_bits(level_q),
		.scan      (scan)
	);

	// register read mux
	always_comb begin
		case (req.address)
			ADDR_CPU_EN:    rd_data = 32'(cpu_en_q);
			ADDR_CPU_PEND:  rd_data = 32'(cpu_pend_q);
			ADDR_LEVEL0:    rd_data = 32'(level_q[0]);
			ADDR_LEVEL1:    rd_data = 32'(level_q[1]);
			ADDR_LEVEL2:    rd_data = 32'(level_q[2]);
			ADDR_HOST_EN:   rd_data = 32'(host_en_q);
			ADDR_HOST_PEND: rd_data = 32'(host_pend_q);
			ADDR_RESET:     rd_data = {22'd0, cable_kind, reset_q};
			ADDR_REQ_LEVEL: rd_data = 32'(req_level_q);
			default:        rd_data = '0;
		endcase
		for (int i = 0; i < NUM_TIMERS; i++) begin
			if (req.address == ADDR_TIMER0 + 16'(i) * TIMER_STRIDE) begin
				rd_data = 32'(timer_q[i]);
			end
		end
	end

	// execute one word against the register state
	always_comb begin
		timer_d     = timer_q;
		level_d     = level_q;
		cpu_en_d    = cpu_en_q;
		cpu_pend_d  = cpu_pend_q;
		host_en_d   = host_en_q;
		host_pend_d = host_pend_q;
		req_level_d = req_level_q;
		reset_d     = reset_q;
		res         = '0;
		case (req.req_type)
			REQ_READ: begin
				res.read_data = rd_data;
			end
			REQ_WRITE: begin
				for (int i = 0; i < NUM_TIMERS; i++) begin
					if (req.address == ADDR_TIMER0 + 16'(i) * TIMER_STRIDE) begin
						timer_d[i] = req.write_data[TIMER_W-1:0];
					end
				end
				case (req.address)
					ADDR_CPU_EN:   cpu_en_d = req.write_data[IRQ_W-1:0];
					ADDR_CPU_PEND: cpu_pend_d = req.write_data[IRQ_W-1:0];
					ADDR_CPU_CLR:  cpu_pend_d = cpu_pend_q & ~req.write_data[IRQ_W-1:0];
					ADDR_LEVEL0:   level_d[0] = req.write_data[7:0];
					ADDR_LEVEL1:   level_d[1] = req.write_data[7:0];
					ADDR_LEVEL2:   level_d[2] = req.write_data[7:0];
					ADDR_HOST_EN:  host_en_d = req.write_data[IRQ_W-1:0];
					ADDR_HOST_PEND: begin
						host_pend_d = req.write_data[IRQ_W-1:0];
						res.host_irq_raise = host_en_q[HOST_KEY_BIT] &
							req.write_data[HOST_KEY_BIT];
					end
					ADDR_HOST_CLR: begin
						host_pend_d = host_pend_clr;
						res.host_irq_clear = ~|(host_pend_clr & host_en_q);
					end
					ADDR_RESET:     reset_d = req.write_data[7:0];
					ADDR_REQ_LEVEL: req_level_d = req.write_data[7:0];
					ADDR_REQ_CLR: begin
						if (req.write_data[0]) begin
							req_level_d = LEVEL_IDLE;
						end
					end
					default: ;
				endcase
			end
			REQ_TICK: begin
				for (int i = 0; i < NUM_TIMERS; i++) begin
					timer_d[i] = {timer_q[i][TIMER_W-1:8], timer_q[i][7:0] + 8'd1};
				end
				cpu_pend_d  = cpu_pend_tick;
				host_pend_d = host_pend_tick;
				// interrupts are only looked at while no request is held
				if (req_level_q == LEVEL_IDLE) begin
					if (scan.found) begin
						req_level_d = {5'd0, scan.level};
						res.cpu_irq_raise = 1'b1;
					end
					res.host_irq_raise = |(host_pend_tick & host_en_q);
				end
			end
			default: ;
		endcase
		res.cpu_run = ~reset_d[0];
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TIMERS; i++) begin
				timer_q[i] <= '0;
			end
			for (int k = 0; k < LEVEL_REGS; k++) begin
				level_q[k] <= '0;
			end
			cpu_en_q    <= CPU_EN_RESET;
			cpu_pend_q  <= '0;
			host_en_q   <= '0;
			host_pend_q <= '0;
			req_level_q <= LEVEL_IDLE;
			reset_q     <= '0;
		end else if (exec) begin
			timer_q     <= timer_d;
			level_q     <= level_d;
			cpu_en_q    <= cpu_en_d;
			cpu_pend_q  <= cpu_pend_d;
			host_en_q   <= host_en_d;
			host_pend_q <= host_pend_d;
			req_level_q <= req_level_d;
			reset_q     <= reset_d;
		end
	end

	`SCTIU_ASSERT(a_raise_holds_level, clk, arst_n, exec && res.cpu_irq_raise |=> req_level_q != LEVEL_IDLE, "cpu interrupt raised but request level left idle")
	`SCTIU_ASSERT(a_clear_leaves_none, clk, arst_n, exec && res.host_irq_clear |=> (host_pend_q & host_en_q) == '0, "host clear pulsed with an enabled pending bit left")
	`SCTIU_ASSERT(a_read_data_only_on_read, clk, arst_n, res.read_data != '0 |-> req.req_type == REQ_READ, "read data driven on a word that is not a read")

endmodule

`default_nettype wire

// File: design/sound_chip_timer_interrupt_unit.sv
// Timer and interrupt unit of a sound processor: three sample timers, sound
// cpu and host pending/enable registers, level mapping and a request level
// register, all reached through one request channel (read, write or tick).
// Every request word gives exactly one response word. Words are taken one
// per clock cycle unless a stalled response backs up into a full input
// register; a request passes through the input register, then the response
// register, before its response is presented. The input side keeps taking
// words while a finished response waits on a stalled output as long as the
// input register is free. The cable kind register is written through its
// own channel, which is always ready.
`default_nettype none
`include "sound_chip_timer_interrupt_unit_assert.svh"

module sound_chip_timer_interrupt_unit import sctiu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	sctiu_cfg_if.sink   cfg,
	sctiu_req_if.sink   req,
	sctiu_rsp_if.source rsp
);

	logic       req_valid_s1;
	req_t       req_s1;
	logic       rsp_valid_s2;
	result_t    rsp_s2;
	logic [1:0] cable_kind_q;
	logic       advance;
	logic       req_take;
	result_t    core_res;

	// handshake: execute when the output register is free or draining
	assign advance   = req_valid_s1 && (!rsp_valid_s2 || rsp.ready);
	assign req.ready = !req_valid_s1 || advance;
	assign req_take  = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	// cable kind register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cable_kind_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			cable_kind_q <= cfg.cable_kind;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (req_take) begin
			req_valid_s1 <= 1'b1;
		end else if (advance) begin
			req_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			req_s1 <= '{req_type: req_type_t'(req.req_type), address: req.address,
				write_data: req.write_data};
		end
	end

	sctiu_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.exec      (advance),
		.req       (req_s1),
		.cable_kind(cable_kind_q),
		.res       (core_res)
	);

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s2 <= 1'b0;
		end else if (advance) begin
			rsp_valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2 <= core_res;
		end
	end

	assign rsp.valid          = rsp_valid_s2;
	assign rsp.read_data      = rsp_s2.read_data;
	assign rsp.cpu_irq_raise  = rsp_s2.cpu_irq_raise;
	assign rsp.host_irq_raise = rsp_s2.host_irq_raise;
	assign rsp.host_irq_clear = rsp_s2.host_irq_clear;
	assign rsp.cpu_run        = rsp_s2.cpu_run;

	`SCTIU_ASSERT(a_take_fills_input, clk, arst_n, req_take |=> req_valid_s1, "accepted word did not reach the input register")
	`SCTIU_ASSERT(a_exec_fills_output, clk, arst_n, advance |=> rsp_valid_s2, "executed word produced no response")
	`SCTIU_ASSERT(a_rsp_held, clk, arst_n, rsp_valid_s2 && !rsp.ready |=> rsp_valid_s2 && $stable(rsp_s2), "stalled response changed")

endmodule

`default_nettype wire
